### design/fat_ts_pkg.sv
// ----------------------------------------------------------------------------
// fat_ts_pkg
// shared types, constants and small tables for the fat timestamp converter
// ----------------------------------------------------------------------------
package fat_ts_pkg;

  localparam int FAT_W      = 16;
  localparam int EPOCH_W    = 32;
  localparam int PIPE_DEPTH = 7;

  // direction select
  localparam logic FUNC_FAT_TO_EPOCH = 1'b0;
  localparam logic FUNC_EPOCH_TO_FAT = 1'b1;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SHIFT_DAYS    = 719468;
  localparam int DAYS_PER_ERA  = 146097;
  localparam int DAYS_PER_CENT = 36524;
  localparam int DAYS_PER_QUAD = 1460;
  localparam int DAYS_PER_YEAR = 365;
  localparam int FAT_BASE_YEAR = 1980;
  localparam int ERA4_YEAR     = 1600;
  localparam int ERA5_YEAR     = 2000;

  // 1980-01-01 packed
  localparam logic [FAT_W-1:0] FAT_DATE_MIN = 16'h0021;

  // era starts as day counts relative to the unix epoch (mod 2^32)
  localparam logic [31:0] ERA4_DAYS = 32'(4 * DAYS_PER_ERA - SHIFT_DAYS);
  localparam logic [31:0] ERA5_DAYS = 32'(5 * DAYS_PER_ERA - SHIFT_DAYS);

  // era starts on the shifted day axis
  localparam logic [19:0] ERA4_Z = 20'(4 * DAYS_PER_ERA);
  localparam logic [19:0] ERA5_Z = 20'(5 * DAYS_PER_ERA);

  // reciprocal constants, ceil(2^sh / d), exact over the operand ranges used
  localparam int DIV675_SH  = 35;
  localparam int DIV1460_SH = 32;
  localparam int DIV365_SH  = 32;
  localparam int DIV60_SH   = 23;
  localparam int DIV60H_SH  = 17;

  localparam logic [25:0] RECIP_675 =
    26'(((64'd1 << DIV675_SH) + 64'd674) / 64'd675);
  localparam logic [21:0] RECIP_1460 =
    22'(((64'd1 << DIV1460_SH) + 64'd1459) / 64'd1460);
  localparam logic [23:0] RECIP_365 =
    24'(((64'd1 << DIV365_SH) + 64'd364) / 64'd365);
  localparam logic [17:0] RECIP_60 =
    18'(((64'd1 << DIV60_SH) + 64'd59) / 64'd60);
  localparam logic [11:0] RECIP_60H =
    12'(((64'd1 << DIV60H_SH) + 64'd59) / 64'd60);

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch_out;
    logic               bad_date;
  } f2e_res_t;

  typedef struct packed {
    logic [FAT_W-1:0] fat_date_out;
    logic [FAT_W-1:0] fat_time_out;
    logic             clamped_early;
  } e2f_res_t;

  // first day-of-year of each march-based month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // year-of-era / 100 for year-of-era below 400
  function automatic logic [1:0] centuries(input logic [8:0] yoe);
    return {1'b0, yoe >= 9'd100} + {1'b0, yoe >= 9'd200} + {1'b0, yoe >= 9'd300};
  endfunction

endpackage

### design/fat_ts_if.sv
// ----------------------------------------------------------------------------
// fat_ts_if
// request and result channels of the fat timestamp converter
// ----------------------------------------------------------------------------
interface fat_ts_req_if;
  import fat_ts_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [FAT_W-1:0]    fat_date_in;
  logic [FAT_W-1:0]    fat_time_in;
  logic [EPOCH_W-1:0]  epoch_in;

  modport source (output valid, func, fat_date_in, fat_time_in, epoch_in, input ready);
  modport sink   (input valid, func, fat_date_in, fat_time_in, epoch_in, output ready);
endinterface

interface fat_ts_rsp_if;
  import fat_ts_pkg::*;

  logic                valid;
  logic                ready;
  logic [EPOCH_W-1:0]  epoch_out;
  logic [FAT_W-1:0]    fat_date_out;
  logic [FAT_W-1:0]    fat_time_out;
  logic                bad_date;
  logic                clamped_early;

  modport source (output valid, epoch_out, fat_date_out, fat_time_out, bad_date,
                  clamped_early, input ready);
  modport sink   (input valid, epoch_out, fat_date_out, fat_time_out, bad_date,
                  clamped_early, output ready);
endinterface

### design/fat_ts_f2e.sv
// ----------------------------------------------------------------------------
// fat_ts_f2e
// fat date/time to epoch seconds, four compute stages plus alignment stages
// ----------------------------------------------------------------------------
module fat_ts_f2e (
  input  logic                                 clk,
  input  logic [fat_ts_pkg::PIPE_DEPTH-1:0]    stage_en,
  input  logic [fat_ts_pkg::FAT_W-1:0]         fat_date_in,
  input  logic [fat_ts_pkg::FAT_W-1:0]         fat_time_in,
  output fat_ts_pkg::f2e_res_t                 res
);
  import fat_ts_pkg::*;

  // stage 1: field decode, march-based year and day of year
  logic [6:0]  yoff;
  logic [3:0]  mon;
  logic [4:0]  day;
  logic        jan_feb;
  logic [11:0] year;
  logic        era5_nxt;
  logic [8:0]  yoe_nxt;
  logic [3:0]  mshift;
  logic [8:0]  doy_nxt;
  logic        bad_nxt;

  logic [8:0]       yoe1_r;
  logic             era5_1_r;
  logic [8:0]       doy1_r;
  logic             bad1_r;
  logic [FAT_W-1:0] ftime1_r;

  always_comb begin
    yoff     = fat_date_in[15:9];
    mon      = fat_date_in[8:5];
    day      = fat_date_in[4:0];
    jan_feb  = (mon <= 4'd2);
    year     = 12'(FAT_BASE_YEAR) + {5'd0, yoff} - {11'd0, jan_feb};
    era5_nxt = (year >= 12'(ERA5_YEAR));
    yoe_nxt  = era5_nxt ? 9'(year - 12'(ERA5_YEAR)) : 9'(year - 12'(ERA4_YEAR));
    mshift   = (mon > 4'd2) ? (mon - 4'd3) : (mon + 4'd9);
    doy_nxt  = month_start(mshift) + {4'd0, day} - 9'd1;
    bad_nxt  = (mon == 4'd0) || (mon > 4'd12) || (day == 5'd0);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      yoe1_r   <= yoe_nxt;
      era5_1_r <= era5_nxt;
      doy1_r   <= doy_nxt;
      bad1_r   <= bad_nxt;
      ftime1_r <= fat_time_in;
    end
  end

  // stage 2: day count and second of day
  logic [31:0] days_full;
  logic [15:0] days_nxt;
  logic [16:0] secs_nxt;

  logic [15:0] days2_r;
  logic [16:0] secs2_r;
  logic        bad2_r;

  always_comb begin
    days_full = (era5_1_r ? ERA5_DAYS : ERA4_DAYS)
              + 32'(yoe1_r) * 32'(DAYS_PER_YEAR)
              + 32'(yoe1_r >> 2)
              - 32'(centuries(yoe1_r))
              + 32'(doy1_r);
    days_nxt  = days_full[15:0];
    secs_nxt  = 17'(ftime1_r[15:11]) * 17'd3600
              + 17'(ftime1_r[10:5]) * 17'd60
              + 17'({ftime1_r[4:0], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      days2_r <= days_nxt;
      secs2_r <= secs_nxt;
      bad2_r  <= bad1_r;
    end
  end

  // stage 3: days times seconds per day
  logic [31:0] prod3_r;
  logic [16:0] secs3_r;
  logic        bad3_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      prod3_r <= {16'd0, days2_r} * 32'(SECS_PER_DAY);
      secs3_r <= secs2_r;
      bad3_r  <= bad2_r;
    end
  end

  // stage 4: final sum, wraps mod 2^32; then alignment with the other path
  f2e_res_t res_r [3:PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      res_r[3].epoch_out <= bad3_r ? '0 : prod3_r + {15'd0, secs3_r};
      res_r[3].bad_date  <= bad3_r;
    end
    for (int i = 4; i < PIPE_DEPTH; i++) begin
      if (stage_en[i]) begin
        res_r[i] <= res_r[i-1];
      end
    end
  end

  assign res = res_r[PIPE_DEPTH-1];

endmodule

### design/fat_ts_e2f.sv
// ----------------------------------------------------------------------------
// fat_ts_e2f
// epoch seconds to fat date/time, seven stage civil-from-days pipeline
// ----------------------------------------------------------------------------
module fat_ts_e2f (
  input  logic                                 clk,
  input  logic [fat_ts_pkg::PIPE_DEPTH-1:0]    stage_en,
  input  logic [fat_ts_pkg::EPOCH_W-1:0]       epoch_in,
  output fat_ts_pkg::e2f_res_t                 res
);
  import fat_ts_pkg::*;

  // stage 1: day number, epoch / 86400 as (epoch >> 7) / 675
  logic [50:0] q_prod;
  logic [15:0] q1_r;
  logic [31:0] ep1_r;

  assign q_prod = 51'(epoch_in[31:7]) * 51'(RECIP_675);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      q1_r  <= 16'(q_prod >> DIV675_SH);
      ep1_r <= epoch_in;
    end
  end

  // stage 2: second of day, day of era
  logic [31:0] day_secs;
  logic [19:0] z;
  logic        era5_nxt;
  logic [16:0] s2_r;
  logic        era5_2_r;
  logic [17:0] doe2_r;

  always_comb begin
    day_secs = 32'(q1_r) * 32'(SECS_PER_DAY);
    z        = 20'(q1_r) + 20'(SHIFT_DAYS);
    era5_nxt = (z >= ERA5_Z);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s2_r     <= 17'(ep1_r - day_secs);
      era5_2_r <= era5_nxt;
      doe2_r   <= 18'(z - (era5_nxt ? ERA5_Z : ERA4_Z));
    end
  end

  // stage 3: leap corrections of the day of era, minute of day
  logic [39:0] quad_prod;
  logic [34:0] min_prod;
  logic [2:0]  cent_nxt;

  logic [17:0] doe3_r;
  logic [6:0]  quad3_r;
  logic [2:0]  cent3_r;
  logic        last3_r;
  logic        era5_3_r;
  logic [16:0] s3_r;
  logic [10:0] mt3_r;

  always_comb begin
    quad_prod = 40'(doe2_r) * 40'(RECIP_1460);
    min_prod  = 35'(s2_r) * 35'(RECIP_60);
    cent_nxt  = 3'd0;
    for (int k = 1; k <= 4; k++) begin
      cent_nxt = cent_nxt + {2'd0, doe2_r >= 18'(k * DAYS_PER_CENT)};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      doe3_r   <= doe2_r;
      quad3_r  <= 7'(quad_prod >> DIV1460_SH);
      cent3_r  <= cent_nxt;
      last3_r  <= (doe2_r == 18'(DAYS_PER_ERA - 1));
      era5_3_r <= era5_2_r;
      s3_r     <= s2_r;
      mt3_r    <= 11'(min_prod >> DIV60_SH);
    end
  end

  // stage 4: year of era, hour, second
  logic [17:0] yv;
  logic [41:0] yoe_prod;
  logic [22:0] hr_prod;

  logic [8:0]  yoe4_r;
  logic [17:0] doe4_r;
  logic        era5_4_r;
  logic [4:0]  hr4_r;
  logic [10:0] mt4_r;
  logic [5:0]  sec4_r;

  always_comb begin
    yv       = doe3_r - 18'(quad3_r) + 18'(cent3_r) - {17'd0, last3_r};
    yoe_prod = 42'(yv) * 42'(RECIP_365);
    hr_prod  = 23'(mt3_r) * 23'(RECIP_60H);
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      yoe4_r   <= 9'(yoe_prod >> DIV365_SH);
      doe4_r   <= doe3_r;
      era5_4_r <= era5_3_r;
      hr4_r    <= 5'(hr_prod >> DIV60H_SH);
      mt4_r    <= mt3_r;
      sec4_r   <= 6'(s3_r - 17'(mt3_r) * 17'd60);
    end
  end

  // stage 5: day of year, minute, march-based year
  logic [17:0] yday;
  logic [8:0]  doy5_r;
  logic [11:0] year5_r;
  logic [4:0]  hr5_r;
  logic [5:0]  min5_r;
  logic [5:0]  sec5_r;

  assign yday = 18'(yoe4_r) * 18'(DAYS_PER_YEAR) + 18'(yoe4_r >> 2)
              - 18'(centuries(yoe4_r));

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      doy5_r  <= 9'(doe4_r - yday);
      year5_r <= 12'(yoe4_r) + (era5_4_r ? 12'(ERA5_YEAR) : 12'(ERA4_YEAR));
      hr5_r   <= hr4_r;
      min5_r  <= 6'(mt4_r - 11'(hr4_r) * 11'd60);
      sec5_r  <= sec4_r;
    end
  end

  // stage 6: march-based month by threshold count
  logic [3:0]  mp_nxt;
  logic [3:0]  mp6_r;
  logic [8:0]  doy6_r;
  logic [11:0] year6_r;
  logic [4:0]  hr6_r;
  logic [5:0]  min6_r;
  logic [5:0]  sec6_r;

  always_comb begin
    mp_nxt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      mp_nxt = mp_nxt + {3'd0, doy5_r >= month_start(4'(k))};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      mp6_r   <= mp_nxt;
      doy6_r  <= doy5_r;
      year6_r <= year5_r;
      hr6_r   <= hr5_r;
      min6_r  <= min5_r;
      sec6_r  <= sec5_r;
    end
  end

  // stage 7: civil date, clamp and packing
  logic        jan_feb;
  logic [3:0]  mon;
  logic [4:0]  day;
  logic [11:0] year;
  logic        clamp;
  e2f_res_t    res_nxt;
  e2f_res_t    res_r;

  always_comb begin
    jan_feb = (mp6_r >= 4'd10);
    mon     = jan_feb ? (mp6_r - 4'd9) : (mp6_r + 4'd3);
    day     = 5'(doy6_r - month_start(mp6_r) + 9'd1);
    year    = year6_r + {11'd0, jan_feb};
    clamp   = (year < 12'(FAT_BASE_YEAR));
    res_nxt.clamped_early = clamp;
    if (clamp) begin
      res_nxt.fat_date_out = FAT_DATE_MIN;
      res_nxt.fat_time_out = '0;
    end else begin
      res_nxt.fat_date_out = {7'(year - 12'(FAT_BASE_YEAR)), mon, day};
      res_nxt.fat_time_out = {hr6_r, min6_r, sec6_r[5:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### design/fat_timestamp_converter.sv
// ----------------------------------------------------------------------------
// fat_timestamp_converter
// packed fat directory timestamps to and from unix epoch seconds
// ----------------------------------------------------------------------------
// requests arrive on in_req (valid/ready); func selects the direction:
// fat date/time to epoch seconds, or epoch seconds to fat date/time.
// every request gives exactly one result on out_rsp, in request order.
// the fields of the unused direction read as zero; bad_date marks a month
// outside 1..12 or a zero day, clamped_early marks dates before 1980.
// out_rsp.valid rises once the request has passed seven register stages,
// the first loaded at acceptance; the depth is set by the civil-from-days
// path (three reciprocal multiplies in series) and the fat-to-epoch path
// is padded to the same depth.
// throughput is one request per cycle while out_rsp.ready stays high.
// each stage holds its own valid bit and a stage advances whenever the
// next one is empty or advancing, so a stalled receiver only holds the
// occupied stages; empty stages keep filling and in_req.ready drops once
// the pipeline is full.
// reset clears all valid bits; the block keeps no other state.
// ----------------------------------------------------------------------------
module fat_timestamp_converter (
  input  logic         clk,
  input  logic         rst_n,
  fat_ts_req_if.sink   in_req,
  fat_ts_rsp_if.source out_rsp
);
  import fat_ts_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  logic [PIPE_DEPTH-1:0] stage_en;
  logic [PIPE_DEPTH-1:0] func_r;

  f2e_res_t f2e_res;
  e2f_res_t e2f_res;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    stage_en[PIPE_DEPTH-1] = !vld_r[PIPE_DEPTH-1] || out_rsp.ready;
    for (int i = PIPE_DEPTH-2; i >= 0; i--) begin
      stage_en[i] = !vld_r[i] || stage_en[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = stage_en[0] ? in_req.valid : vld_r[0];
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      vld_nxt[i] = stage_en[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      func_r[0] <= in_req.func;
    end
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      if (stage_en[i]) begin
        func_r[i] <= func_r[i-1];
      end
    end
  end

  fat_ts_f2e u_f2e (
    .clk         (clk),
    .stage_en    (stage_en),
    .fat_date_in (in_req.fat_date_in),
    .fat_time_in (in_req.fat_time_in),
    .res         (f2e_res)
  );

  fat_ts_e2f u_e2f (
    .clk      (clk),
    .stage_en (stage_en),
    .epoch_in (in_req.epoch_in),
    .res      (e2f_res)
  );

  assign in_req.ready  = stage_en[0];
  assign out_rsp.valid = vld_r[PIPE_DEPTH-1];

  always_comb begin
    if (func_r[PIPE_DEPTH-1] == FUNC_EPOCH_TO_FAT) begin
      out_rsp.epoch_out     = '0;
      out_rsp.fat_date_out  = e2f_res.fat_date_out;
      out_rsp.fat_time_out  = e2f_res.fat_time_out;
      out_rsp.bad_date      = 1'b0;
      out_rsp.clamped_early = e2f_res.clamped_early;
    end else begin
      out_rsp.epoch_out     = f2e_res.epoch_out;
      out_rsp.fat_date_out  = '0;
      out_rsp.fat_time_out  = '0;
      out_rsp.bad_date      = f2e_res.bad_date;
      out_rsp.clamped_early = 1'b0;
    end
  end

endmodule

### design/fat_ts_checker.sv
// ----------------------------------------------------------------------------
// fat_ts_checker
// port-level checks of the fat timestamp converter, bound to the top level
// ----------------------------------------------------------------------------
module fat_ts_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [fat_ts_pkg::EPOCH_W-1:0]    epoch_out,
  input logic [fat_ts_pkg::FAT_W-1:0]      fat_date_out,
  input logic [fat_ts_pkg::FAT_W-1:0]      fat_time_out,
  input logic                              bad_date,
  input logic                              clamped_early
);
  import fat_ts_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({epoch_out, fat_date_out, fat_time_out, bad_date, clamped_early}))
    else $error("result changed while stalled");

  // a bad date gives an all-zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_date |-> epoch_out == '0 && fat_date_out == '0 &&
      fat_time_out == '0 && !clamped_early)
    else $error("bad date with nonzero result");

  // clamping gives 1980-01-01 00:00 and nothing else
  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clamped_early |-> fat_date_out == FAT_DATE_MIN &&
      fat_time_out == '0 && epoch_out == '0)
    else $error("clamped result is not 1980-01-01 00:00");

  // the two directions never mix in one result
  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && epoch_out != '0 |-> fat_date_out == '0 && fat_time_out == '0)
    else $error("epoch and fat fields both set");

endmodule

bind fat_timestamp_converter fat_ts_checker u_fat_ts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .epoch_out     (out_rsp.epoch_out),
  .fat_date_out  (out_rsp.fat_date_out),
  .fat_time_out  (out_rsp.fat_time_out),
  .bad_date      (out_rsp.bad_date),
  .clamped_early (out_rsp.clamped_early)
);
